[hdl/assert_macros.svh]
// Assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define CMALU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define CMALU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cmalu_pkg.sv]
package cmalu_pkg;

  // Field and datapath widths
  localparam int REQ_W   = 3;
  localparam int DATA_W  = 32;
  localparam int MOD_W   = 31;
  localparam int CNT_W   = $clog2(DATA_W + 1);
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(3329);

  // Register indexes
  localparam logic REG_MODULUS = 1'b0;

  // Operation codes
  localparam logic [REQ_W-1:0] OP_ADD = 3'd0;
  localparam logic [REQ_W-1:0] OP_SUB = 3'd1;
  localparam logic [REQ_W-1:0] OP_MUL = 3'd2;
  localparam logic [REQ_W-1:0] OP_DIV = 3'd3;
  localparam logic [REQ_W-1:0] OP_EXP = 3'd4;
  localparam logic [REQ_W-1:0] OP_INV = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REDA,
    S_LDB,
    S_REDB,
    S_DISPATCH,
    S_ADDSUB,
    S_MM,
    S_MMDONE,
    S_SIGN,
    S_CENT,
    S_EU_CHK,
    S_EU_DIV,
    S_EU_UPD,
    S_EU_END,
    S_EXP_SKIP,
    S_EXP_BIT
  } state_t;

  // Divider control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  // Modular double-and-add control
  typedef struct packed {
    logic clr;
    logic dbl;
    logic add;
    logic din;
  } mac_ctrl_t;

endpackage

[hdl/cmalu_chan_if.sv]
interface cmalu_in_if;
  import cmalu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [DATA_W-1:0] operand_a;
  logic signed [DATA_W-1:0] operand_b;

  modport source (output valid, output req_type, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input req_type, input operand_a, input operand_b,
                output ready);
endinterface

interface cmalu_out_if;
  import cmalu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic                     no_inverse;

  modport source (output valid, output result, output no_inverse, input ready);
  modport sink (input valid, input result, input no_inverse, output ready);
endinterface

[hdl/cmalu_div.sv]
module cmalu_div #(
  parameter int WIDTH = cmalu_pkg::DATA_W
) (
  input  logic                  clk,
  input  cmalu_pkg::div_ctrl_t  ctrl,
  input  logic [WIDTH-1:0]      dividend,
  input  logic [WIDTH-1:0]      divisor,
  output logic [WIDTH-1:0]      rem,
  output logic                  qbit
);
  import cmalu_pkg::*;

  logic [WIDTH-1:0] dvd_r;
  logic [WIDTH-1:0] dvs_r;
  logic [WIDTH-1:0] rem_r;
  logic             qbit_r;
  logic [WIDTH-1:0] trial;
  logic             ge;

  // Bring down the next dividend bit; remainder stays below the divisor
  assign trial = {rem_r[WIDTH-2:0], dvd_r[WIDTH-1]};
  assign ge    = (trial >= dvs_r);

  // One restoring step per cycle while step is set, quotient bit out MSB first
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      dvd_r  <= dividend;
      dvs_r  <= divisor;
      rem_r  <= '0;
      qbit_r <= 1'b0;
    end else if (ctrl.step) begin
      rem_r  <= ge ? (trial - dvs_r) : trial;
      qbit_r <= ge;
      dvd_r  <= {dvd_r[WIDTH-2:0], 1'b0};
    end
  end

  assign rem  = rem_r;
  assign qbit = qbit_r;

endmodule

[hdl/cmalu_mac.sv]
module cmalu_mac #(
  parameter int WIDTH = cmalu_pkg::DATA_W
) (
  input  logic                  clk,
  input  cmalu_pkg::mac_ctrl_t  ctrl,
  input  logic [WIDTH-1:0]      y_in,
  input  logic [WIDTH-1:0]      q,
  output logic [WIDTH-1:0]      acc
);
  import cmalu_pkg::*;

  logic [WIDTH-1:0] acc_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] dbl_val;
  logic [WIDTH-1:0] sum_val;

  // Both stay below 2Q, so one conditional subtract reduces them
  assign dbl_val = {acc_r[WIDTH-2:0], 1'b0};
  assign sum_val = acc_r + y_r;

  // Horner form: acc = 2*acc + bit*y, reduced mod Q after each half
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
      y_r   <= y_in;
    end else if (ctrl.dbl) begin
      acc_r <= (dbl_val >= q) ? (dbl_val - q) : dbl_val;
    end else if (ctrl.add && ctrl.din) begin
      acc_r <= (sum_val >= q) ? (sum_val - q) : sum_val;
    end
  end

  assign acc = acc_r;

endmodule

[hdl/centered_modular_alu.sv]
// Modular arithmetic unit over a configured modulus Q.
// Input channel in_if carries req_type, operand_a and operand_b; one result
// beat (result, no_inverse) leaves on out_if for every input beat.
// Q sits in the register at byte address 0 of the cfg_ port; write it only
// while the unit is idle. Reset sets Q to 3329 and empties the unit.
// Operands are first reduced by a serial restoring divider, one bit a cycle.
// Products mod Q come from a double-and-add unit taking each multiplier
// bit as a double step followed by an add step.
// Q below 2 or an unused code goes straight to the result hand-off.
// Inverse runs Euclid steps until the remainder reaches zero; divide adds
// one modular multiply after the inverse. Exponentiate skips leading zero
// exponent bits, then squares for each remaining bit and multiplies for
// each set bit.
// One item is in work at a time; in_if.ready is high only when idle.
// A finished result waits in an output register, so the next item is taken
// while the receiver stalls; a second result then waits until it drains.
module centered_modular_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  cmalu_in_if.sink                        in_if,
  cmalu_out_if.source                     out_if,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cmalu_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [cmalu_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [cmalu_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                            cfg_pready
);
  import cmalu_pkg::*;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_W - 1);
  localparam logic [CNT_W-1:0] ALL_BITS = CNT_W'(DATA_W);

  state_t state_r, state_nxt;

  logic [MOD_W-1:0]         modulus_r;
  logic [REQ_W-1:0]         op_r;
  logic                     asgn_r;
  logic [DATA_W-1:0]        b_r;
  logic [DATA_W-1:0]        ra_r;
  logic [DATA_W-1:0]        rb_r;
  logic [CNT_W-1:0]         cnt_r;
  logic                     ph_r;
  logic [DATA_W-1:0]        xs_r;
  logic [DATA_W-1:0]        r_r, nr_r, t_r, nt_r;
  logic [DATA_W-1:0]        e_r;
  logic [CNT_W-1:0]         ecnt_r;
  logic [DATA_W-1:0]        exp_acc_r;
  logic                     exp_mul_r;
  logic signed [DATA_W:0]   v_r;
  logic [DATA_W-1:0]        fin_res_r;
  logic                     fin_flag_r;
  // Result ready to hand off once set
  logic                     fin_done_r;
  logic                     out_valid_r;
  logic [DATA_W-1:0]        out_result_r;
  logic                     out_flag_r;

  logic [DATA_W-1:0]        q32;
  logic signed [DATA_W:0]   q33;
  logic signed [DATA_W:0]   qh33;
  logic                     q_small;
  logic                     accept;
  logic                     cfg_wr;
  logic [DATA_W-1:0]        a_mag;
  logic [DATA_W-1:0]        b_mag;
  logic [DATA_W-1:0]        na;
  logic [DATA_W-1:0]        nb;
  logic                     bsgn;
  logic                     mm_last;
  logic                     out_free;

  logic signed [DATA_W:0]   sa, sb, s_sum, s_trunc, m_signed, v_cent;
  logic [DATA_W-1:0]        t_sub, eu_tmp;
  logic                     neg;

  div_ctrl_t                div_c;
  logic [DATA_W-1:0]        div_dvd, div_dvs, div_rem;
  logic                     div_qbit;
  mac_ctrl_t                mac_c;
  logic [DATA_W-1:0]        mac_y, mac_acc;
  logic [DATA_W-1:0]        mm_x;
  logic                     mm_go;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_MODULUS) ? PDATA_W'(modulus_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == REG_MODULUS)) begin
      modulus_r <= cfg_pwdata[MOD_W-1:0];
    end
  end

  // Modulus views
  assign q32     = DATA_W'(modulus_r);
  assign q33     = $signed({2'b00, modulus_r});
  assign qh33    = $signed({3'b000, modulus_r[MOD_W-1:1]});
  assign q_small = (modulus_r < MOD_W'(2));

  assign accept  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // Operand magnitudes and nonnegative residues
  assign a_mag = in_if.operand_a[DATA_W-1] ? (DATA_W'(0) - in_if.operand_a) : in_if.operand_a;
  assign b_mag = b_r[DATA_W-1] ? (DATA_W'(0) - b_r) : b_r;
  assign bsgn  = b_r[DATA_W-1];
  assign na    = (asgn_r && (ra_r != '0)) ? (q32 - ra_r) : ra_r;
  assign nb    = (bsgn && (div_rem != '0)) ? (q32 - div_rem) : div_rem;

  // Add and subtract on truncated residues, then truncating remainder
  assign sa      = asgn_r ? -$signed({1'b0, ra_r}) : $signed({1'b0, ra_r});
  assign sb      = bsgn ? -$signed({1'b0, rb_r}) : $signed({1'b0, rb_r});
  assign s_sum   = (op_r == OP_SUB) ? (sa - sb) : (sa + sb);
  assign s_trunc = (s_sum >= q33) ? (s_sum - q33) :
                   (s_sum <= -q33) ? (s_sum + q33) : s_sum;

  // Sign of a truncated product
  assign neg      = (op_r == OP_MUL) ? (asgn_r ^ bsgn) : asgn_r;
  assign m_signed = neg ? -$signed({1'b0, mac_acc}) : $signed({1'b0, mac_acc});

  // Move into the centred range
  assign v_cent = (v_r > qh33) ? (v_r - q33) :
                  (v_r <= -qh33) ? (v_r + q33) : v_r;

  // Euclid coefficient update t - quo*nt mod Q
  assign t_sub  = t_r - mac_acc;
  assign eu_tmp = (t_r >= mac_acc) ? t_sub : (t_sub + q32);

  assign mm_last = ph_r && (cnt_r == LAST_BIT);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and unit control
  always_comb begin
    state_nxt   = state_r;
    in_if.ready = 1'b0;
    div_c       = '0;
    div_dvd     = b_mag;
    div_dvs     = q32;
    mac_c       = '0;
    mac_y       = '0;
    mm_x        = '0;
    mm_go       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          if (q_small || (in_if.req_type > OP_INV)) begin
            state_nxt = S_EU_END;
          end else begin
            div_c.load = 1'b1;
            div_dvd    = a_mag;
            state_nxt  = S_REDA;
          end
        end
      end
      S_REDA: begin
        div_c.step = 1'b1;
        if (cnt_r == LAST_BIT) state_nxt = S_LDB;
      end
      S_LDB: begin
        div_c.load = 1'b1;
        state_nxt  = S_REDB;
      end
      S_REDB: begin
        div_c.step = 1'b1;
        if (cnt_r == LAST_BIT) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (op_r)
          OP_ADD, OP_SUB: state_nxt = S_ADDSUB;
          OP_MUL: begin
            mm_go     = 1'b1;
            mm_x      = ra_r;
            mac_y     = div_rem;
            state_nxt = S_MM;
          end
          OP_DIV, OP_INV: state_nxt = S_EU_CHK;
          OP_EXP: state_nxt = S_EXP_SKIP;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ADDSUB: state_nxt = S_CENT;
      S_MM: begin
        if (!ph_r) begin
          mac_c.dbl = 1'b1;
        end else begin
          mac_c.add = 1'b1;
          mac_c.din = xs_r[DATA_W-1];
        end
        if (mm_last) state_nxt = S_MMDONE;
      end
      S_MMDONE: begin
        if (op_r == OP_EXP) begin
          if (!exp_mul_r && e_r[DATA_W-1]) begin
            mm_go     = 1'b1;
            mm_x      = mac_acc;
            mac_y     = na;
            state_nxt = S_MM;
          end else begin
            state_nxt = S_EXP_BIT;
          end
        end else begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: state_nxt = S_CENT;
      S_CENT: state_nxt = S_EU_END;
      S_EU_CHK: begin
        if (nr_r == '0) begin
          state_nxt = S_EU_END;
        end else begin
          div_c.load = 1'b1;
          div_dvd    = r_r;
          div_dvs    = nr_r;
          mm_go      = 1'b1;
          mac_y      = nt_r;
          state_nxt  = S_EU_DIV;
        end
      end
      S_EU_DIV: begin
        if (!ph_r) begin
          div_c.step = 1'b1;
          mac_c.dbl  = 1'b1;
        end else begin
          mac_c.add = 1'b1;
          mac_c.din = div_qbit;
        end
        if (mm_last) state_nxt = S_EU_UPD;
      end
      S_EU_UPD: state_nxt = S_EU_CHK;
      S_EU_END: begin
        // Also serves as the result hand-off for every operation
        if (out_free) state_nxt = S_IDLE;
        if ((op_r == OP_DIV) && (fin_flag_r == 1'b0) && !fin_done_r) begin
          mm_go     = 1'b1;
          mm_x      = ra_r;
          mac_y     = t_r;
          state_nxt = S_MM;
        end
      end
      S_EXP_SKIP: begin
        if (e_r[DATA_W-1]) state_nxt = S_EXP_BIT;
      end
      S_EXP_BIT: begin
        if (ecnt_r == '0) begin
          state_nxt = S_EU_END;
        end else begin
          mm_go     = 1'b1;
          mm_x      = exp_acc_r;
          mac_y     = exp_acc_r;
          state_nxt = S_MM;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    mac_c.clr = mm_go;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (mm_go) begin
      xs_r  <= mm_x;
      cnt_r <= '0;
      ph_r  <= 1'b0;
    end else if (div_c.load) begin
      cnt_r <= '0;
      ph_r  <= 1'b0;
    end else if ((state_r == S_REDA) || (state_r == S_REDB)) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if ((state_r == S_MM) || (state_r == S_EU_DIV)) begin
      ph_r <= !ph_r;
      if (ph_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        xs_r  <= {xs_r[DATA_W-2:0], 1'b0};
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_r       <= in_if.req_type;
          asgn_r     <= in_if.operand_a[DATA_W-1];
          b_r        <= in_if.operand_b;
          fin_res_r  <= '0;
          fin_flag_r <= q_small && ((in_if.req_type == OP_DIV) ||
                                    (in_if.req_type == OP_INV));
          fin_done_r <= q_small || (in_if.req_type > OP_INV);
        end
      end
      S_LDB: ra_r <= div_rem;
      S_DISPATCH: begin
        rb_r <= div_rem;
        // Euclid start: r = Q, nr = residue to invert, t = 0, nt = 1
        r_r  <= q32;
        nr_r <= (op_r == OP_DIV) ? nb : na;
        t_r  <= '0;
        nt_r <= DATA_W'(1);
        e_r       <= b_r;
        ecnt_r    <= ALL_BITS;
        exp_acc_r <= DATA_W'(1);
        exp_mul_r <= 1'b0;
        if ((op_r == OP_EXP) && (bsgn || (b_r == '0))) begin
          ecnt_r <= '0;
          e_r    <= {1'b1, {(DATA_W-1){1'b0}}};
        end
      end
      S_ADDSUB: v_r <= s_trunc;
      S_SIGN: v_r <= m_signed;
      S_CENT: begin
        fin_res_r  <= v_cent[DATA_W-1:0];
        fin_done_r <= 1'b1;
      end
      S_MMDONE: begin
        if (op_r == OP_EXP) begin
          exp_acc_r <= mac_acc;
          if (!exp_mul_r && e_r[DATA_W-1]) begin
            exp_mul_r <= 1'b1;
          end else begin
            exp_mul_r <= 1'b0;
            e_r       <= {e_r[DATA_W-2:0], 1'b0};
            ecnt_r    <= ecnt_r - CNT_W'(1);
          end
        end
      end
      S_EU_UPD: begin
        t_r  <= nt_r;
        nt_r <= eu_tmp;
        r_r  <= nr_r;
        nr_r <= div_rem;
      end
      S_EU_CHK: begin
        if (nr_r == '0) begin
          // gcd must be one for an inverse to exist
          if (r_r != DATA_W'(1)) begin
            fin_flag_r <= 1'b1;
            fin_done_r <= 1'b1;
          end else if (op_r == OP_INV) begin
            fin_res_r  <= t_r;
            fin_done_r <= 1'b1;
          end
        end
      end
      S_EXP_SKIP: begin
        if (!e_r[DATA_W-1]) begin
          e_r    <= {e_r[DATA_W-2:0], 1'b0};
          ecnt_r <= ecnt_r - CNT_W'(1);
        end
      end
      S_EXP_BIT: begin
        if (ecnt_r == '0) begin
          fin_res_r  <= exp_acc_r;
          fin_done_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EU_END) && fin_done_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EU_END) && fin_done_r && out_free) begin
      out_result_r <= fin_res_r;
      out_flag_r   <= fin_flag_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.result     = out_result_r;
  assign out_if.no_inverse = out_flag_r;

  cmalu_div #(
    .WIDTH (DATA_W)
  ) u_div (
    .clk      (clk),
    .ctrl     (div_c),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .rem      (div_rem),
    .qbit     (div_qbit)
  );

  cmalu_mac #(
    .WIDTH (DATA_W)
  ) u_mac (
    .clk  (clk),
    .ctrl (mac_c),
    .y_in (mac_y),
    .q    (q32),
    .acc  (mac_acc)
  );

endmodule

[hdl/cmalu_checker.sv]
`include "assert_macros.svh"

module cmalu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic        out_no_inverse,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pready
);

  // Hold a stalled result beat
  `CMALU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `CMALU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_result) && $stable(out_no_inverse), "stalled result changed")

  // No inverse always comes with a zero result
  `CMALU_ASSERT_NOW(a_flag_zero, out_valid && out_no_inverse, out_result == 32'd0, "flagged result not zero")

  // Busy once an item is taken
  `CMALU_ASSERT_NEXT(a_busy, in_valid && in_ready, !in_ready, "ready while item in work")

  // Register access never waits
  `CMALU_ASSERT_NOW(a_apb_ready, cfg_psel && cfg_penable, cfg_pready, "access stalled")

endmodule

bind centered_modular_alu cmalu_checker u_cmalu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_result     (out_if.result),
  .out_no_inverse (out_if.no_inverse),
  .cfg_psel       (cfg_psel),
  .cfg_penable    (cfg_penable),
  .cfg_pready     (cfg_pready)
);

[tb/tb_centered_modular_alu.sv]
module tb_centered_modular_alu;
  import cmalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     no_inverse;
  } alu_result_t;

  logic clk;
  logic rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  cmalu_in_if  in_if ();
  cmalu_out_if out_if ();

  centered_modular_alu dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Predictor copy of the modulus register
  longint      mod_q;
  alu_result_t pending_results[$];
  int          errors;
  int          beats_sent;
  int          beats_checked;
  int          no_inverse_seen;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("timeout: %0d results still pending", pending_results.size());
    $display("tb_centered_modular_alu failed");
    $finish;
  end

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Residue arithmetic, truncating remainder as the hardware does
  function automatic longint centre(input longint x, input longint q);
    longint r;
    r = x % q;
    if (r > q / 2) r -= q;
    else if (r <= -(q / 2)) r += q;
    return r;
  endfunction

  function automatic longint pos_mod(input longint x, input longint q);
    longint r;
    r = x % q;
    return (r < 0) ? r + q : r;
  endfunction

  function automatic longint pow_mod(input longint base, input longint e, input longint q);
    longint acc, sq;
    longint unsigned bits;
    if (e <= 0) return 1;
    acc  = 1 % q;
    sq   = pos_mod(base, q);
    bits = e;
    while (bits != 0) begin
      if (bits[0]) acc = (acc * sq) % q;
      sq   = (sq * sq) % q;
      bits = bits >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; returns 1 and the inverse in [0,q) when one exists
  function automatic bit inv_mod(input longint x, input longint q, output longint inv);
    longint t, nt, r, nr, quo, tmp;
    t  = 0;
    nt = 1;
    r  = q;
    nr = pos_mod(x, q);
    while (nr != 0) begin
      quo = r / nr;
      tmp = t - quo * nt;
      t   = nt;
      nt  = tmp;
      tmp = r - quo * nr;
      r   = nr;
      nr  = tmp;
    end
    inv = 0;
    if (r != 1) return 0;
    inv = (t < 0) ? t + q : t;
    return 1;
  endfunction

  function automatic alu_result_t predict_result(input logic [REQ_W-1:0] op,
                                                 input logic signed [DATA_W-1:0] opa,
                                                 input logic signed [DATA_W-1:0] opb);
    alu_result_t r;
    longint a, b, q, res, inv;
    a   = opa;
    b   = opb;
    q   = mod_q;
    res = 0;
    r.no_inverse = 1'b0;
    if (q < 2) begin
      r.no_inverse = (op == OP_DIV || op == OP_INV);
    end else begin
      case (op)
        OP_ADD: res = centre((a % q + b % q) % q, q);
        OP_SUB: res = centre((a % q - b % q) % q, q);
        OP_MUL: res = centre(((a % q) * (b % q)) % q, q);
        OP_DIV: begin
          if (inv_mod(b, q, inv)) res = centre(((a % q) * (inv % q)) % q, q);
          else r.no_inverse = 1'b1;
        end
        OP_EXP: res = pow_mod(a, b, q);
        OP_INV: begin
          if (inv_mod(a, q, inv)) res = inv;
          else r.no_inverse = 1'b1;
        end
        default: res = 0;
      endcase
    end
    r.result = res[DATA_W-1:0];
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Send one beat, record its expectation on acceptance
  task automatic send_item(input logic [REQ_W-1:0] op,
                           input logic signed [DATA_W-1:0] a,
                           input logic signed [DATA_W-1:0] b);
    int gap;
    in_if.valid     <= 1'b1;
    in_if.req_type  <= op;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_results.push_back(predict_result(op, a, b));
    beats_sent++;
    gap = gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
      n++;
      if (n > 50000) begin
        $display("drain timeout: %0d results pending", pending_results.size());
        $display("tb_centered_modular_alu failed");
        $finish;
      end
    end
    repeat (10) @(posedge clk);
  endtask

  // Write the modulus while idle, then read it back
  task automatic set_modulus(input logic [MOD_W-1:0] q);
    logic [PDATA_W-1:0] rd;
    end_burst();
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_MODULUS, 2'b00};
    cfg_pwdata  <= {1'b0, q};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    mod_q = q;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[MOD_W-1:0] !== q)
      report($sformatf("modulus read back %0d, wrote %0d", rd[MOD_W-1:0], q));
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %0d", out_if.result));
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (want.no_inverse) no_inverse_seen++;
        if (out_if.result !== want.result)
          report($sformatf("result %0d, want %0d (Q=%0d)", out_if.result, want.result, mod_q));
        if (out_if.no_inverse !== want.no_inverse)
          report($sformatf("no_inverse %b, want %b (Q=%0d)", out_if.no_inverse,
                           want.no_inverse, mod_q));
      end
    end
  end

  // Receiver: runs of ready mixed with stalls
  initial begin
    int len;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 65) begin
        len = $urandom_range(1, 50);
        repeat (len) begin
          out_if.ready <= 1'b1;
          @(posedge clk);
        end
      end else begin
        len = gap_len() + 1;
        repeat (len) begin
          out_if.ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] rand_operand();
    int p;
    logic signed [DATA_W-1:0] v;
    p = $urandom_range(0, 99);
    if (p < 40) v = $urandom();
    else if (p < 70) v = $signed(DATA_W'($urandom_range(0, 200))) - 100;
    else if (p < 80) v = (p[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    else if (p < 90) v = DATA_W'(mod_q * $signed($urandom_range(0, 6) - 3));
    else v = DATA_W'(mod_q / 2 + $signed($urandom_range(0, 2)) - 1);
    return v;
  endfunction

  task automatic random_items(input int count);
    logic [REQ_W-1:0] op;
    logic signed [DATA_W-1:0] a, b;
    repeat (count) begin
      op = ($urandom_range(0, 49) == 0) ? REQ_W'($urandom_range(6, 7))
                                        : REQ_W'($urandom_range(0, 5));
      a = rand_operand();
      b = rand_operand();
      // Keep most exponents short; long ones are slow
      if (op == OP_EXP && $urandom_range(0, 19) != 0)
        b = $signed(DATA_W'($urandom_range(0, 300))) - 4;
      send_item(op, a, b);
    end
  endtask

  task automatic test_directed_ops();
    send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
    send_item(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(OP_SUB, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_item(OP_ADD, 1664, 0);
    send_item(OP_ADD, -1664, 0);
    send_item(OP_MUL, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(OP_MUL, -1, -1);
    send_item(OP_DIV, 7, 0);
    send_item(OP_DIV, 7, 3329);
    send_item(OP_DIV, -5, 3);
    send_item(OP_EXP, 3, 0);
    send_item(OP_EXP, 3, -7);
    send_item(OP_EXP, -2, 11);
    send_item(OP_EXP, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_item(OP_INV, 0, 5);
    send_item(OP_INV, -2, 0);
    send_item(OP_INV, 32'sh7FFF_FFFF, 0);
    send_item(REQ_W'(6), 9, 9);
    send_item(REQ_W'(7), -9, 9);
    end_burst();
  endtask

  task automatic test_modulus_extremes();
    set_modulus(MOD_W'(2));
    send_item(OP_ADD, 1, 1);
    send_item(OP_DIV, 1, 1);
    send_item(OP_INV, 0, 0);
    send_item(OP_EXP, -1, 5);
    set_modulus({MOD_W{1'b1}});
    send_item(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
    send_item(OP_INV, 32'sh8000_0000, 0);
    send_item(OP_DIV, 1, 32'sh7FFF_FFFF);
    send_item(OP_SUB, -1073741823, 1073741824);
    set_modulus(MOD_W'(0));
    send_item(OP_ADD, 5, 5);
    send_item(OP_DIV, 5, 5);
    send_item(OP_INV, 5, 5);
    set_modulus(MOD_W'(1));
    send_item(OP_MUL, 5, 5);
    send_item(OP_INV, 5, 5);
    send_item(OP_EXP, 5, 0);
  endtask

  task automatic test_random_moduli();
    set_modulus(MOD_W'(3329));
    random_items(230);
    set_modulus(MOD_W'(12));
    random_items(200);
    set_modulus(MOD_W'($urandom_range(3, 1000)));
    random_items(200);
    set_modulus(MOD_W'($urandom_range(1 << 20, 32'h7FFF_FFFF)));
    random_items(220);
    set_modulus({MOD_W{1'b1}});
    random_items(220);
    set_modulus(MOD_W'(2));
    random_items(120);
    set_modulus(MOD_W'(65536));
    random_items(120);
    end_burst();
  endtask

  initial begin
    errors          = 0;
    beats_sent      = 0;
    beats_checked   = 0;
    no_inverse_seen = 0;
    mod_q           = 3329;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= OP_ADD;
    in_if.operand_a <= '0;
    in_if.operand_b <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_ops();
    test_modulus_extremes();
    test_random_moduli();
    wait_idle();

    $display("%0d beats sent, %0d results checked, %0d without inverse",
             beats_sent, beats_checked, no_inverse_seen);
    $display("moduli covered: reset value, 0, 1, 2, 12, 65536, random, 2^31-1");
    if (errors == 0) begin
      $display("tb_centered_modular_alu passed");
    end else begin
      $display("tb_centered_modular_alu failed");
    end
    $finish;
  end

endmodule
